>>> sv/sample_format_converter_core_macros.svh
// assertion macros for the sample format converter
`ifndef SAMPLE_FORMAT_CONVERTER_CORE_MACROS_SVH
`define SAMPLE_FORMAT_CONVERTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// condition holds in the same cycle
`define SFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfc assertion failed");
// condition holds in the next cycle
`define SFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfc assertion failed");
`else
`define SFC_ASSERT_NOW(lbl, ante, cons)
`define SFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/sfc_pkg.sv
package sfc_pkg;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_I2F  = 2'd1,
    MODE_F2I  = 2'd2,
    MODE_I2I  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_SRC    = 3'd1,
    REG_DST    = 3'd2,
    REG_GAIN   = 3'd3,
    REG_OFFSET = 3'd4
  } reg_idx_t;

  localparam logic [4:0]  SRC_BITS_RST = 5'd8;
  localparam logic [4:0]  DST_BITS_RST = 5'd16;
  localparam logic [4:0]  F2I_DST_BITS = 5'd16;
  localparam logic [31:0] GAIN_RST     = 32'h3F80_0000;
  localparam logic [31:0] OFFSET_RST   = 32'h0000_0000;
  localparam logic [31:0] DEFAULT_NAN  = 32'hFFC0_0000;
  localparam logic [30:0] MAX16_MAG    = 31'h477F_FF00;

  // unnormalized float value on its way to rounding
  typedef struct packed {
    logic               sgn;
    logic signed [11:0] exp;
    logic [51:0]        man;
    logic               stk;
    logic               spc;
    logic [31:0]        spc_val;
  } nrm_t;

  typedef struct packed {
    mode_t       mode;
    logic        bad;
    logic [31:0] direct;
  } side_t;

  // leading zero count of a 52 bit word
  function automatic logic [5:0] lzc52(input logic [51:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd52;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(51 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // round to nearest even and pack, man has its leading one at bit 51
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                             input logic [51:0] man, input logic stk);
    logic [51:0]        m2;
    logic [51:0]        mask;
    logic signed [11:0] shv;
    logic [5:0]         sh;
    logic               st;
    logic               st2;
    logic               up;
    logic [7:0]         ef;
    logic [30:0]        pk;
    shv = 12'sd1 - e;
    sh = (shv > 12'sd53) ? 6'd53 : shv[5:0];
    mask = (52'd1 << sh) - 52'd1;
    if (e <= 12'sd0) begin
      m2 = man >> sh;
      st = stk | (|(man & mask));
      ef = 8'd0;
    end else begin
      m2 = man;
      st = stk;
      ef = e[7:0];
    end
    st2 = st | (|m2[26:0]);
    up = m2[27] & (st2 | m2[28]);
    pk = {ef, m2[50:28]} + 31'(up);
    if (e >= 12'sd255) begin
      return {sgn, 8'hFF, 23'd0};
    end
    return {sgn, pk};
  endfunction

  function automatic logic depth_ok(input logic [4:0] d);
    return (d == 5'd8) || (d == 5'd9) || (d == 5'd10) || (d == 5'd12) ||
           (d == 5'd14) || (d == 5'd16);
  endfunction

  // exact conversion of a 16 bit unsigned integer to single
  function automatic logic [31:0] int_to_float(input logic [15:0] x);
    logic [3:0]  lz;
    logic        found;
    logic [15:0] sx;
    logic [7:0]  e;
    lz = 4'd0;
    found = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!found && x[i]) begin
        lz = 4'(15 - i);
        found = 1'b1;
      end
    end
    sx = x << lz;
    e = 8'd142 - 8'(lz);
    if (x == 16'd0) begin
      return 32'd0;
    end
    return {1'b0, e, sx[14:0], 8'd0};
  endfunction

  // round to nearest even and clip to 0..65535
  function automatic logic [31:0] clip16(input logic [31:0] r);
    logic [7:0]  e;
    logic [4:0]  sh;
    logic [4:0]  shm1;
    logic [23:0] x;
    logic [23:0] i;
    logic [23:0] stmask;
    logic        up;
    logic [15:0] res;
    e = r[30:23];
    sh = 5'(8'd150 - e);
    shm1 = sh - 5'd1;
    x = {1'b1, r[22:0]};
    i = x >> sh;
    stmask = (24'd1 << shm1) - 24'd1;
    up = x[shm1] & ((|(x & stmask)) | i[0]);
    res = i[15:0] + 16'(up);
    if (e == 8'hFF && r[22:0] != 23'd0) begin
      return 32'd0;
    end
    if (r[31] || r[30:0] == 31'd0) begin
      return 32'd0;
    end
    if (r[30:0] >= MAX16_MAG) begin
      return 32'd65535;
    end
    if (e < 8'd126) begin
      return 32'd0;
    end
    return {16'd0, res};
  endfunction

endpackage

>>> sv/sfc_fmul.sv
module sfc_fmul (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  output sfc_pkg::nrm_t prod
);
  import sfc_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic [47:0] mprod;
  logic        spc;
  logic [31:0] spc_val;

  // operand classification
  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    sgn    = a[31] ^ b[31];
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    mprod  = 48'(ma) * 48'(mb);
    spc     = 1'b1;
    spc_val = {sgn, 31'd0};
    if (a_nan) begin
      spc_val = a | 32'h0040_0000;
    end else if (b_nan) begin
      spc_val = b | 32'h0040_0000;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      spc_val = DEFAULT_NAN;
    end else if (a_inf || b_inf) begin
      spc_val = {sgn, 8'hFF, 23'd0};
    end else if (!(a_zero || b_zero)) begin
      spc = 1'b0;
    end
  end

  // mantissa product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod.sgn     <= sgn;
      prod.exp     <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
      prod.man     <= {mprod, 4'd0};
      prod.stk     <= 1'b0;
      prod.spc     <= spc;
      prod.spc_val <= spc_val;
    end
  end

endmodule

>>> sv/sfc_fadd.sv
module sfc_fadd (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  output sfc_pkg::nrm_t sum
);
  import sfc_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
  logic [31:0] x, y;
  logic [7:0]  ex, ey, d;
  logic [49:0] xw, yw, ys, ymask;
  logic        stk;
  logic [50:0] s;
  logic        spc;
  logic [31:0] spc_val;

  // classify, align the smaller operand and add
  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    swap   = (b[30:0] > a[30:0]);
    x      = swap ? b : a;
    y      = swap ? a : b;
    ex     = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey     = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d      = ex - ey;
    xw     = {x[30:23] != 8'd0, x[22:0], 26'd0};
    yw     = {y[30:23] != 8'd0, y[22:0], 26'd0};
    ymask  = (50'd1 << d[5:0]) - 50'd1;
    if (d >= 8'd50) begin
      ys  = 50'd0;
      stk = 1'b1;
    end else begin
      ys  = yw >> d;
      stk = |(yw & ymask);
    end
    ys[0] = ys[0] | stk;
    if (x[31] ^ y[31]) begin
      s = {1'b0, xw} - {1'b0, ys};
    end else begin
      s = {1'b0, xw} + {1'b0, ys};
    end
    spc     = 1'b1;
    spc_val = 32'd0;
    if (a_nan) begin
      spc_val = a | 32'h0040_0000;
    end else if (b_nan) begin
      spc_val = b | 32'h0040_0000;
    end else if (a_inf && b_inf && (a[31] != b[31])) begin
      spc_val = DEFAULT_NAN;
    end else if (a_inf) begin
      spc_val = a;
    end else if (b_inf) begin
      spc_val = b;
    end else if (a_zero && b_zero) begin
      spc_val = {a[31] & b[31], 31'd0};
    end else if (a_zero) begin
      spc_val = b;
    end else if (b_zero) begin
      spc_val = a;
    end else if (s != 51'd0) begin
      spc = 1'b0;
    end
  end

  // aligned sum register
  always_ff @(posedge clk) begin
    if (en) begin
      sum.sgn     <= x[31];
      sum.exp     <= $signed({4'd0, ex}) + 12'sd1;
      sum.man     <= {s, 1'b0};
      sum.stk     <= 1'b0;
      sum.spc     <= spc;
      sum.spc_val <= spc_val;
    end
  end

endmodule

>>> sv/sfc_nrm_rnd.sv
module sfc_nrm_rnd (
  input  logic          clk,
  input  logic          en,
  input  sfc_pkg::nrm_t raw,
  output logic [31:0]   res
);
  import sfc_pkg::*;

  nrm_t       norm;
  logic [5:0] lz;

  assign lz = lzc52(raw.man);

  // normalize stage
  always_ff @(posedge clk) begin
    if (en) begin
      norm.sgn     <= raw.sgn;
      norm.man     <= raw.man << lz;
      norm.exp     <= raw.exp - $signed({6'd0, lz});
      norm.stk     <= raw.stk;
      norm.spc     <= raw.spc;
      norm.spc_val <= raw.spc_val;
    end
  end

  // round stage
  always_ff @(posedge clk) begin
    if (en) begin
      res <= norm.spc ? norm.spc_val : round_pack(norm.sgn, norm.exp, norm.man, norm.stk);
    end
  end

endmodule

>>> sv/sample_format_converter_core.sv
// one request per cycle accepted while the output register is empty or taken
// stages: front decode, multiply, normalize, round, add, normalize, round, output
// the whole pipeline advances whenever the output register is empty or taken
// reset: synchronous, clears all stage valid bits and loads register defaults
// (copy mode, 8 bit source, 16 bit destination, gain 1.0, offset 0.0)
`include "sample_format_converter_core_macros.svh"

module sample_format_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample,
  output logic        bad_combination,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sfc_pkg::*;

  localparam int STAGES = 7;

  mode_t       conv_mode;
  logic [4:0]  src_bits, dst_bits;
  logic [31:0] gain_bits, offset_bits;

  logic              en;
  logic [STAGES-1:0] vld;
  side_t             side [STAGES];
  side_t             side_in;
  logic [31:0]       a_in, a_q;
  logic [15:0]       int_val;
  logic [23:0]       shifted, maxv;
  nrm_t              prod, sum;
  logic [31:0]       p_val, r_val;
  mode_t             out_mode;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      conv_mode   <= MODE_COPY;
      src_bits    <= SRC_BITS_RST;
      dst_bits    <= DST_BITS_RST;
      gain_bits   <= GAIN_RST;
      offset_bits <= OFFSET_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODE:   conv_mode   <= mode_t'(cfg_data[1:0]);
        REG_SRC:    src_bits    <= cfg_data[4:0];
        REG_DST:    dst_bits    <= cfg_data[4:0];
        REG_GAIN:   gain_bits   <= cfg_data;
        REG_OFFSET: offset_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // front decode: depth checks, integer paths, float operand
  always_comb begin
    int_val = (src_bits == 5'd8) ? {8'd0, in_sample[7:0]} : in_sample[15:0];
    shifted = {8'd0, int_val} << (dst_bits - src_bits);
    maxv    = (24'd1 << dst_bits) - 24'd1;
    side_in.mode   = conv_mode;
    side_in.bad    = 1'b0;
    side_in.direct = 32'd0;
    a_in           = in_sample;
    case (conv_mode)
      MODE_COPY: begin
        side_in.direct = in_sample;
      end
      MODE_I2F: begin
        side_in.bad = !depth_ok(src_bits);
        a_in        = int_to_float(int_val);
      end
      MODE_F2I: begin
        side_in.bad = (dst_bits != F2I_DST_BITS);
      end
      MODE_I2I: begin
        side_in.bad = !depth_ok(src_bits) || !depth_ok(dst_bits) || (dst_bits < src_bits);
        if (!side_in.bad) begin
          side_in.direct = {8'd0, (shifted > maxv) ? maxv : shifted};
        end
      end
      default: ;
    endcase
  end

  // valid bits and side data move with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[STAGES-2:0], in_valid};
      out_valid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      a_q     <= a_in;
      for (int k = 1; k < STAGES; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // gain multiply, then offset add
  sfc_fmul u_fmul (.clk(clk), .en(en), .a(a_q), .b(gain_bits), .prod(prod));
  sfc_nrm_rnd u_mul_rnd (.clk(clk), .en(en), .raw(prod), .res(p_val));
  sfc_fadd u_fadd (.clk(clk), .en(en), .a(p_val), .b(offset_bits), .sum(sum));
  sfc_nrm_rnd u_add_rnd (.clk(clk), .en(en), .raw(sum), .res(r_val));

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_mode        <= side[STAGES-1].mode;
      bad_combination <= side[STAGES-1].bad;
      if (side[STAGES-1].bad) begin
        out_sample <= 32'd0;
      end else begin
        case (side[STAGES-1].mode)
          MODE_I2F: out_sample <= r_val;
          MODE_F2I: out_sample <= clip16(r_val);
          default:  out_sample <= side[STAGES-1].direct;
        endcase
      end
    end
  end

  `SFC_ASSERT_NOW(a_bad_zero, out_valid && bad_combination, out_sample == 32'd0)
  `SFC_ASSERT_NOW(a_copy_ok, out_valid && out_mode == MODE_COPY, !bad_combination)
  `SFC_ASSERT_NOW(a_f2i_range, out_valid && out_mode == MODE_F2I, out_sample[31:16] == 16'd0)

endmodule
